// File: hdl/lphf_pkg.sv
// ---------------------------------------------------------------------------
// lphf_pkg
// Shared constants for the linear-probe hash find/insert core.
// ---------------------------------------------------------------------------
package lphf_pkg;

  localparam int KEY_W          = 64;
  localparam int HALF_W         = 32;
  localparam int SLOT_W         = 12;
  localparam int OCC_W          = 13;
  localparam int CFG_W          = 4;
  localparam int TABLE_LOG2_DEF = 12;
  localparam int MIX_SHIFT      = 33;

  localparam logic [CFG_W-1:0] INDEX_BITS_RST = 4'd12;
  localparam logic [OCC_W-1:0] OCC_MAX        = 13'h1fff;

  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ce_b9fe_1a85_ec53;

endpackage

// File: hdl/linear_probe_hash_find_insert_core.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_find_insert_core
// Find-or-insert of 64-bit keys in an open-addressed table with linear
// probing. Each key is mixed with the 64-bit murmur finalizer, masked to
// 2^index_bits slots (index_bits clamped to 1..TABLE_LOG2), and slots are
// probed upward with wrap until the key or a free slot turns up; a free slot
// takes the key and bumps occupancy. A full table yields table_full, slot 0,
// no insert. After reset every slot of the memory is swept clear; during the
// sweep no key beat is taken (config writes still are). Hashing runs on one
// shared 32x32 multiplier (six partial products) and overlaps the probe of
// the previous key; a probe reads the memory once per slot visited, so long
// probe chains slow the key rate. The result register lets the next key
// start while a result waits.
// ---------------------------------------------------------------------------
module linear_probe_hash_find_insert_core #(
  parameter int TABLE_LOG2 = lphf_pkg::TABLE_LOG2_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lphf_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lphf_pkg::KEY_W-1:0]   in_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lphf_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_inserted,
  output logic                         out_table_full,
  output logic [lphf_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int CW       = lphf_pkg::CFG_W;
  localparam int MAX_BITS = (TABLE_LOG2 < 15) ? TABLE_LOG2 : 15;
  localparam logic [CW-1:0] MaxBitsC = CW'(MAX_BITS);

  logic [CW-1:0]                 idx_bits_r;
  logic [CW-1:0]                 act_bits;
  logic [TABLE_LOG2-1:0]         mask;
  logic                          clearing;
  logic                          hash_valid, hash_ready;
  logic [lphf_pkg::KEY_W-1:0]    hash_val, hash_key;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_bits_r <= lphf_pkg::INDEX_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      idx_bits_r <= cfg_data;
    end
  end

  always_comb begin
    if (idx_bits_r == '0) begin
      act_bits = CW'(1);
    end else if (idx_bits_r > MaxBitsC) begin
      act_bits = MaxBitsC;
    end else begin
      act_bits = idx_bits_r;
    end
    for (int i = 0; i < TABLE_LOG2; i++) begin
      mask[i] = (i < int'(act_bits));
    end
  end

  lphf_hash u_hash (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_key     (in_key),
    .clearing   (clearing),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_val   (hash_val),
    .hash_key   (hash_key)
  );

  lphf_probe #(
    .TABLE_LOG2 (TABLE_LOG2)
  ) u_probe (
    .clk            (clk),
    .rst_n          (rst_n),
    .hash_valid     (hash_valid),
    .hash_ready     (hash_ready),
    .hash_val       (hash_val),
    .hash_key       (hash_key),
    .mask           (mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot       (out_slot),
    .out_inserted   (out_inserted),
    .out_table_full (out_table_full),
    .out_occupancy  (out_occupancy),
    .clearing       (clearing)
  );

  a_occ_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_occupancy >= $past(out_occupancy)))
    else $error("occupancy decreased");

  a_full_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (!out_inserted && (out_slot == '0)))
    else $error("table_full beat with insert or nonzero slot");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!out_valid && !in_ready && !hash_ready))
    else $error("activity during clear pass");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inserted) |-> (out_occupancy != '0))
    else $error("insert beat with zero occupancy");

endmodule

// File: hdl/lphf_hash.sv
// ---------------------------------------------------------------------------
// lphf_hash
// Iterative 64-bit finalizer mix on one shared 32x32 multiplier, three
// partial products per 64-bit multiply.
// ---------------------------------------------------------------------------
module lphf_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lphf_pkg::KEY_W-1:0]  in_key,
  input  logic                        clearing,
  output logic                        hash_valid,
  input  logic                        hash_ready,
  output logic [lphf_pkg::KEY_W-1:0]  hash_val,
  output logic [lphf_pkg::KEY_W-1:0]  hash_key
);

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_RUN  = 3'b010,
    H_DONE = 3'b100
  } hstate_t;

  localparam int HW = lphf_pkg::HALF_W;
  localparam int KW = lphf_pkg::KEY_W;

  hstate_t           state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              second_r, second_nxt;
  logic [KW-1:0]     v_r, acc_r, key_r;
  logic [HW-1:0]     mul_a, mul_b, c_lo, c_hi, hi_sum;
  logic [KW-1:0]     prod, mixed, mixed_x;
  logic              take;

  assign in_ready   = (state_r == H_IDLE) && !clearing;
  assign take       = in_valid && in_ready;
  assign hash_valid = (state_r == H_DONE);
  assign hash_val   = v_r;
  assign hash_key   = key_r;

  assign c_lo = second_r ? lphf_pkg::MIX_C2[HW-1:0]  : lphf_pkg::MIX_C1[HW-1:0];
  assign c_hi = second_r ? lphf_pkg::MIX_C2[KW-1:HW] : lphf_pkg::MIX_C1[KW-1:HW];

  always_comb begin
    case (phase_r)
      2'd0: begin
        mul_a = v_r[HW-1:0];
        mul_b = c_lo;
      end
      2'd1: begin
        mul_a = v_r[KW-1:HW];
        mul_b = c_lo;
      end
      default: begin
        mul_a = v_r[HW-1:0];
        mul_b = c_hi;
      end
    endcase
  end

  assign prod    = KW'(mul_a) * KW'(mul_b);
  assign hi_sum  = acc_r[KW-1:HW] + prod[HW-1:0];
  assign mixed   = {hi_sum, acc_r[HW-1:0]};
  assign mixed_x = mixed ^ (mixed >> lphf_pkg::MIX_SHIFT);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    second_nxt = second_r;
    unique case (state_r)
      H_IDLE: begin
        if (take) begin
          state_nxt  = H_RUN;
          phase_nxt  = 2'd0;
          second_nxt = 1'b0;
        end
      end
      H_RUN: begin
        if (phase_r == 2'd2) begin
          phase_nxt = 2'd0;
          if (second_r) begin
            state_nxt = H_DONE;
          end else begin
            second_nxt = 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      H_DONE: begin
        if (hash_ready) begin
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= H_IDLE;
      phase_r  <= 2'd0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      v_r   <= in_key ^ (in_key >> lphf_pkg::MIX_SHIFT);
      key_r <= in_key;
    end else if (state_r == H_RUN) begin
      case (phase_r)
        2'd0:    acc_r <= prod;
        2'd1:    acc_r <= mixed;
        default: v_r   <= mixed_x;
      endcase
    end
  end

endmodule

// File: hdl/lphf_probe.sv
// ---------------------------------------------------------------------------
// lphf_probe
// Slot memory {used, key} with a linear probe sequencer, clear pass after
// reset, occupancy counter and result register.
// ---------------------------------------------------------------------------
module lphf_probe #(
  parameter int TABLE_LOG2 = lphf_pkg::TABLE_LOG2_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         hash_valid,
  output logic                         hash_ready,
  input  logic [lphf_pkg::KEY_W-1:0]   hash_val,
  input  logic [lphf_pkg::KEY_W-1:0]   hash_key,
  input  logic [TABLE_LOG2-1:0]        mask,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lphf_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_inserted,
  output logic                         out_table_full,
  output logic [lphf_pkg::OCC_W-1:0]   out_occupancy,
  output logic                         clearing
);

  typedef enum logic [2:0] {
    P_CLEAR = 3'b001,
    P_IDLE  = 3'b010,
    P_CHECK = 3'b100
  } pstate_t;

  localparam int TL    = TABLE_LOG2;
  localparam int KW    = lphf_pkg::KEY_W;
  localparam int DEPTH = 2 ** TL;

  logic [KW:0] mem [DEPTH];

  pstate_t                      state_r, state_nxt;
  logic [TL-1:0]                idx_r, cnt_r, clr_r;
  logic [KW-1:0]                key_r;
  logic [KW:0]                  rdata_r;
  logic [lphf_pkg::OCC_W-1:0]   occ_r;
  logic                         out_valid_r;
  logic [lphf_pkg::SLOT_W-1:0]  slot_r;
  logic                         ins_r, full_r;

  logic                         re, we;
  logic [TL-1:0]                raddr, waddr, idx_next;
  logic [KW:0]                  wdata;
  logic                         used, match, last, out_free, finish, take;

  assign used     = rdata_r[KW];
  assign match    = (rdata_r[KW-1:0] == key_r);
  assign last     = (cnt_r == mask);
  assign out_free = !out_valid_r || out_ready;
  assign idx_next = (idx_r + TL'(1)) & mask;
  assign take     = (state_r == P_IDLE) && hash_valid;
  assign finish   = (state_r == P_CHECK) && out_free && (!used || match || last);

  assign hash_ready     = (state_r == P_IDLE);
  assign clearing       = (state_r == P_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_slot       = slot_r;
  assign out_inserted   = ins_r;
  assign out_table_full = full_r;
  assign out_occupancy  = occ_r;

  always_comb begin
    state_nxt = state_r;
    re        = 1'b0;
    we        = 1'b0;
    raddr     = idx_next;
    waddr     = idx_r;
    wdata     = {1'b1, key_r};
    unique case (state_r)
      P_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        if (&clr_r) begin
          state_nxt = P_IDLE;
        end
      end
      P_IDLE: begin
        raddr = hash_val[TL-1:0] & mask;
        if (hash_valid) begin
          re        = 1'b1;
          state_nxt = P_CHECK;
        end
      end
      P_CHECK: begin
        if (finish) begin
          we        = !used;
          state_nxt = P_IDLE;
        end else if (used && !match && !last) begin
          re = 1'b1;
        end
      end
      default: state_nxt = P_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= P_CLEAR;
      clr_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == P_CLEAR) begin
        clr_r <= clr_r + TL'(1);
      end
      if (finish && !used && (occ_r != lphf_pkg::OCC_MAX)) begin
        occ_r <= occ_r + lphf_pkg::OCC_W'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r <= raddr;
      key_r <= hash_key;
      cnt_r <= '0;
    end else if (re) begin
      idx_r <= idx_next;
      cnt_r <= cnt_r + TL'(1);
    end
    if (finish) begin
      slot_r <= (used && !match) ? '0 : lphf_pkg::SLOT_W'(idx_r);
      ins_r  <= !used;
      full_r <= used && !match;
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear-probe hash find/insert core. A directed
// table covers the size clamps, full tables and repeats. Random phases follow
// that vary the table size, sender gaps and receiver stalls, with one long
// receiver hold-off. Every result beat is checked against a local
// hash-table model, or against its hint where a directed row gives one.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT       = 2_000_000;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 50;
  localparam int N_ROWS      = 26;
  localparam int N_SLOTS     = 1 << lphf_pkg::TABLE_LOG2_DEF;

  localparam logic [lphf_pkg::KEY_W-1:0] ALL1 = {lphf_pkg::KEY_W{1'b1}};
  localparam logic [lphf_pkg::KEY_W-1:0] TOP  = {1'b1, {(lphf_pkg::KEY_W-1){1'b0}}};

  typedef enum logic {ROW_KEY, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic                       known;
    logic                       ins;
    logic                       full;
    logic [lphf_pkg::OCC_W-1:0] occ;
  } hint_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [lphf_pkg::KEY_W-1:0] value;
    hint_t                      hint;
  } row_t;

  typedef struct packed {
    logic [lphf_pkg::SLOT_W-1:0] slot;
    logic                        inserted;
    logic                        table_full;
    logic [lphf_pkg::OCC_W-1:0]  occupancy;
  } lookup_t;

  localparam hint_t NO_HINT = '0;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [lphf_pkg::CFG_W-1:0]   cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [lphf_pkg::KEY_W-1:0]   in_key;
  hint_t                        in_hint;
  logic                         out_valid;
  logic                         out_ready;
  logic [lphf_pkg::SLOT_W-1:0]  out_slot;
  logic                         out_inserted;
  logic                         out_table_full;
  logic [lphf_pkg::OCC_W-1:0]   out_occupancy;

  // model state
  bit                           used_tbl [N_SLOTS];
  logic [lphf_pkg::KEY_W-1:0]   key_tbl  [N_SLOTS];
  logic [lphf_pkg::OCC_W-1:0]   key_total    = '0;
  logic [lphf_pkg::CFG_W-1:0]   index_bits_q = lphf_pkg::INDEX_BITS_RST;

  lookup_t                      lookup_q [$];
  logic [lphf_pkg::KEY_W-1:0]   sent_keys [$];
  int unsigned                  err_cnt    = 0;
  int unsigned                  cycles     = 0;
  int unsigned                  idle_pct   = 0;
  int unsigned                  stall_pct  = 0;
  int unsigned                  hold_left  = 0;
  bit                           hold_req   = 0;

  row_t dir_rows [N_ROWS] = '{
    '{ROW_CFG, 64'd0, NO_HINT},
    '{ROW_KEY, 64'd0, '{1'b1, 1'b1, 1'b0, 13'd1}},
    '{ROW_KEY, 64'd0, '{1'b1, 1'b0, 1'b0, 13'd1}},
    '{ROW_KEY, ALL1,  '{1'b1, 1'b1, 1'b0, 13'd2}},
    '{ROW_KEY, TOP,   '{1'b1, 1'b0, 1'b1, 13'd2}},
    '{ROW_KEY, ALL1,  '{1'b1, 1'b0, 1'b0, 13'd2}},
    '{ROW_CFG, 64'd15, NO_HINT},
    '{ROW_KEY, 64'd1, '{1'b1, 1'b1, 1'b0, 13'd3}},
    '{ROW_KEY, TOP,   '{1'b1, 1'b1, 1'b0, 13'd4}},
    '{ROW_KEY, 64'd0, '{1'b1, 1'b0, 1'b0, 13'd4}},
    '{ROW_KEY, 64'd1, '{1'b1, 1'b0, 1'b0, 13'd4}},
    '{ROW_CFG, 64'd12, NO_HINT},
    '{ROW_KEY, 64'h0123_4567_89ab_cdef, '{1'b1, 1'b1, 1'b0, 13'd5}},
    '{ROW_CFG, 64'd1, NO_HINT},
    '{ROW_KEY, 64'h0123_4567_89ab_cdef, '{1'b1, 1'b0, 1'b1, 13'd5}},
    '{ROW_KEY, ALL1,  '{1'b1, 1'b0, 1'b0, 13'd5}},
    '{ROW_CFG, 64'd2, NO_HINT},
    '{ROW_KEY, 64'd2, NO_HINT},
    '{ROW_KEY, 64'd3, NO_HINT},
    '{ROW_KEY, 64'd4, NO_HINT},
    '{ROW_KEY, 64'd5, NO_HINT},
    '{ROW_KEY, 64'd6, NO_HINT},
    '{ROW_KEY, 64'd7, NO_HINT},
    '{ROW_CFG, 64'd4, NO_HINT},
    '{ROW_KEY, 64'hffff_ffff_0000_0000, NO_HINT},
    '{ROW_KEY, 64'h0000_0000_ffff_ffff, NO_HINT}
  };

  logic [lphf_pkg::CFG_W-1:0] phase_bits [N_PHASES] = '{
    4'd12, 4'd1, 4'd15, 4'd0, 4'd3, 4'd12, 4'd2, 4'd13, 4'd12, 4'd6, 4'd9, 4'd12
  };

  linear_probe_hash_find_insert_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot       (out_slot),
    .out_inserted   (out_inserted),
    .out_table_full (out_table_full),
    .out_occupancy  (out_occupancy)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [lphf_pkg::KEY_W-1:0] mix64(input logic [lphf_pkg::KEY_W-1:0] v);
    v = v ^ (v >> lphf_pkg::MIX_SHIFT);
    v = v * lphf_pkg::MIX_C1;
    v = v ^ (v >> lphf_pkg::MIX_SHIFT);
    v = v * lphf_pkg::MIX_C2;
    v = v ^ (v >> lphf_pkg::MIX_SHIFT);
    return v;
  endfunction

  // find or insert one key in the model table
  function automatic lookup_t probe_table(input logic [lphf_pkg::KEY_W-1:0] key);
    lookup_t                    r;
    int unsigned                bits;
    int unsigned                mask;
    int unsigned                idx;
    int unsigned                n;
    logic [lphf_pkg::KEY_W-1:0] h;
    bits = index_bits_q;
    if (bits < 1) bits = 1;
    if (bits > lphf_pkg::TABLE_LOG2_DEF) bits = lphf_pkg::TABLE_LOG2_DEF;
    mask = (1 << bits) - 1;
    h = mix64(key);
    idx = h[31:0] & mask;
    r = '{slot: '0, inserted: 1'b0, table_full: 1'b1, occupancy: '0};
    for (n = 0; n <= mask; n++) begin
      if (!used_tbl[idx]) begin
        used_tbl[idx] = 1'b1;
        key_tbl[idx] = key;
        if (key_total != lphf_pkg::OCC_MAX) key_total = key_total + 1'b1;
        r.slot = lphf_pkg::SLOT_W'(idx);
        r.inserted = 1'b1;
        r.table_full = 1'b0;
        break;
      end
      if (key_tbl[idx] == key) begin
        r.slot = lphf_pkg::SLOT_W'(idx);
        r.table_full = 1'b0;
        break;
      end
      idx = (idx + 1) & mask;
    end
    r.occupancy = key_total;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic logic [lphf_pkg::KEY_W-1:0] pick_key();
    int unsigned                sel;
    logic [lphf_pkg::KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    if (sel < 40 && sent_keys.size() > 0)
      return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    if (sel < 70)
      return {$urandom, $urandom};
    if (sel < 80) begin
      k = 64'd1 << $urandom_range(0, lphf_pkg::KEY_W - 1);
      return $urandom_range(0, 1) ? k : ~k;
    end
    if (sel < 90)
      return lphf_pkg::KEY_W'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: return '0;
      1: return ALL1;
      default: return TOP;
    endcase
  endfunction

  // sample at the rising edge: config, accepted keys, result beats
  always @(posedge clk) begin : monitor_b
    lookup_t want;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_n) begin
      if (cfg_valid && cfg_ready) index_bits_q = cfg_data;
      if (in_valid && in_ready) begin
        want = probe_table(in_key);
        if (in_hint.known) begin
          want.inserted = in_hint.ins;
          want.table_full = in_hint.full;
          want.occupancy = in_hint.occ;
          if (in_hint.full) want.slot = '0;
        end
        lookup_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          $error("result beat with nothing expected");
          err_cnt++;
        end else begin
          want = lookup_q.pop_front();
          check_field("slot", want.slot, out_slot);
          check_field("inserted", want.inserted, out_inserted);
          check_field("table_full", want.table_full, out_table_full);
          check_field("occupancy", want.occupancy, out_occupancy);
        end
      end
    end
  end

  // receiver: random stalls plus a counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300 + $urandom_range(0, 100);
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_key(input logic [lphf_pkg::KEY_W-1:0] key, input hint_t h);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_key <= key;
    in_hint <= h;
    sent_keys.push_back(key);
    do @(posedge clk); while (!in_ready);
  endtask

  // drain all results, then write the register
  task automatic set_index_bits(input logic [lphf_pkg::CFG_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (lookup_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim_b
    int p;
    int i;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_key = '0;
    in_hint = NO_HINT;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG)
        set_index_bits(dir_rows[r].value[lphf_pkg::CFG_W-1:0]);
      else send_key(dir_rows[r].value, dir_rows[r].hint);
    end

    for (p = 0; p < N_PHASES; p++) begin
      set_index_bits(phase_bits[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // long receiver hold-off while keys keep coming
      if (p == 4) hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) send_key(pick_key(), NO_HINT);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (lookup_q.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/lphf_pkg.sv
hdl/lphf_hash.sv
hdl/lphf_probe.sv
hdl/linear_probe_hash_find_insert_core.sv
sim/tb_top.sv
